[hdl/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and character helpers for the integer to ASCII
// formatter and its digit unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

  typedef enum logic [1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_CHAR = 2'd3
  } kind_t;

  // Operations of the shared digit unit
  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_LOAD_DEC = 3'd1,
    OP_LOAD_HEX = 3'd2,
    OP_DABBLE   = 3'd3,
    OP_SHIFT    = 3'd4
  } op_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOWA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[hdl/itoa_digit_unit.sv]
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Digit register with a shift-add-3 binary to BCD step, a direct hex load
// and a digit shift; the top digit is always presented for output.
// ----------------------------------------------------------------------------
module itoa_digit_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  itoa_pkg::op_t         op,
  input  logic [VALUE_BITS-1:0] load_val,
  output logic [3:0]            top_digit
);
  import itoa_pkg::*;

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HDIG = (VALUE_BITS + 3) / 4;
  localparam int DW   = NDIG * 4;
  localparam int HW   = HDIG * 4;

  logic [DW-1:0]         dig_r, dig_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [DW-1:0]         adj;
  logic [HW-1:0]         hex_pad;

  // add 3 to every digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = dig_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = dig_r[i*4 +: 4];
      end
    end
  end

  assign hex_pad = HW'(load_val);

  always_comb begin
    dig_nxt = dig_r;
    mag_nxt = mag_r;
    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD_DEC: begin
        dig_nxt = '0;
        mag_nxt = load_val;
      end
      OP_LOAD_HEX: begin
        // align the hex nibbles to the top of the digit register
        dig_nxt = DW'(hex_pad) << (DW - HW);
      end
      OP_DABBLE: begin
        dig_nxt = {adj[DW-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = mag_r << 1;
      end
      OP_SHIFT: begin
        dig_nxt = dig_r << 4;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    mag_r <= mag_nxt;
  end

  assign top_digit = dig_r[DW-1 -: 4];

endmodule

[hdl/integer_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one value as ASCII text in signed or unsigned decimal, lowercase
// hex, or as a single raw character.
// ----------------------------------------------------------------------------
// Input channel: in_tuser carries the format kind, in_tdata the value.
// Output channel: one character per transfer on out_tdata, out_tlast high on
// the final character of a request.
// Decimal: the value passes through a shift-add-3 BCD loop, one bit per
// cycle. Each of the NDIG digit positions is then either dropped as a leading
// zero or emitted, and a negative value gets a '-' ahead of its digits.
// Hex: the nibbles load directly, so the BCD loop is skipped; leading zeros
// are dropped the same way. Zero prints as a single '0'.
// Character kind: the low byte is written to the output register in the
// accept cycle, and the block stays idle.
// in_tready is high only while the block is idle and its output register can
// take a character. A stalled receiver holds the current character in the
// output register and holds the sign and digit steps. Reset returns to idle
// and empties the output register; no state persists between requests.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,   // [VALUE_BITS-1:0] value
  input  logic [1:0]                          in_tuser,   // [1:0] kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] char_out
  output logic                                out_tlast
);
  import itoa_pkg::*;

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HDIG = (VALUE_BITS + 3) / 4;
  localparam int CW   = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [7:0]            ochar_r, ochar_nxt;
  logic                  olast_r, olast_nxt;
  op_t                   op;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] mag;
  logic                  is_neg;
  logic [3:0]            top_digit;
  logic                  can_load;
  logic                  accept;
  kind_t                 kind;

  assign val      = in_tdata[VALUE_BITS-1:0];
  assign kind     = kind_t'(in_tuser);
  assign is_neg   = (kind == KIND_SDEC) && val[VALUE_BITS-1];
  assign mag      = is_neg ? (~val + VALUE_BITS'(1)) : val;
  assign can_load = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && can_load;
  assign accept   = in_tvalid && in_tready;

  itoa_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digits (
    .clk       (clk),
    .op        (op),
    .load_val  (mag),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    neg_nxt    = neg_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    op         = OP_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt = is_neg;
          case (kind)
            KIND_CHAR: begin
              ovalid_nxt = 1'b1;
              ochar_nxt  = val[7:0];
              olast_nxt  = 1'b1;
            end
            KIND_HEX: begin
              op        = OP_LOAD_HEX;
              cnt_nxt   = CW'(HDIG);
              state_nxt = S_SKIP;
            end
            default: begin
              op        = OP_LOAD_DEC;
              cnt_nxt   = CW'(NDIG);
              bit_nxt   = BW'(VALUE_BITS);
              state_nxt = S_CONV;
            end
          endcase
        end
      end
      S_CONV: begin
        op      = OP_DABBLE;
        bit_nxt = bit_r - BW'(1);
        if (bit_r == BW'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == 4'd0 && cnt_r != CW'(1)) begin
          op      = OP_SHIFT;
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = CH_MINUS;
          olast_nxt  = 1'b0;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = digit_to_ascii(top_digit);
          olast_nxt  = (cnt_r == CW'(1));
          op         = OP_SHIFT;
          cnt_nxt    = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cnt_r   <= cnt_nxt;
    bit_r   <= bit_nxt;
    neg_r   <= neg_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule
